/* rtl/suffix_automaton_index_assert.svh */
`ifndef SUFFIX_AUTOMATON_INDEX_ASSERT_SVH
`define SUFFIX_AUTOMATON_INDEX_ASSERT_SVH
// same-cycle implication, checked outside reset
`define SAI_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("suffix automaton index: check failed");
// next-cycle implication, checked outside reset
`define SAI_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("suffix automaton index: check failed");
`endif

/* rtl/sai_pkg.sv */
package sai_pkg;
    localparam int TEXT_MAX   = 4096;
    localparam int ALPHA_SIZE = 26;
    localparam int NODE_AW    = 13;
    localparam int SYM_W      = 5;
    localparam int TRANS_AW   = NODE_AW + SYM_W;
    localparam int LINK_W     = 14;
    localparam int LEN_W      = 13;
    localparam int END_W      = 12;
    localparam int CNT_W      = 14;
    localparam int NODE_W     = END_W + LINK_W + LEN_W;
    localparam logic [LINK_W-1:0] LINK_NONE = {LINK_W{1'b1}};

    localparam logic REQ_APPEND = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_MISS = 2'd2
    } t_status;

    typedef struct packed {
        logic [END_W-1:0]  fe;
        logic [LINK_W-1:0] link;
        logic [LEN_W-1:0]  len;
    } t_node;

    typedef struct packed {
        logic                we;
        logic [TRANS_AW-1:0] waddr;
        logic [NODE_AW-1:0]  wdata;
        logic [TRANS_AW-1:0] raddr;
    } t_tport;

    typedef struct packed {
        logic               we;
        logic [NODE_AW-1:0] waddr;
        t_node              wdata;
        logic [NODE_AW-1:0] raddr;
    } t_nport;

    typedef struct packed {
        logic             valid;
        t_status          status;
        logic [END_W-1:0] end_pos;
    } t_result;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_CLR, S_WRD, S_WCHK, S_TCHK, S_COPY,
        S_RRD, S_RCHK, S_TFIX, S_FIN, S_QCHK, S_QFE, S_DONE
    } t_state;
endpackage

/* rtl/sai_ram.sv */
module sai_ram #(
    parameter int W  = 8,
    parameter int AW = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);
    logic [W-1:0] mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

/* rtl/sai_ctrl.sv */
module sai_ctrl import sai_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_req,
    input  logic [SYM_W-1:0]   i_sym,
    input  logic               i_restart,
    output t_tport             o_tport,
    input  logic [NODE_AW-1:0] i_trd,
    output t_nport             o_nport,
    input  t_node              i_nrd,
    input  logic               i_slot_free,
    output t_result            o_res
);
    localparam logic [SYM_W-1:0] SYM_LAST = SYM_W'(ALPHA_SIZE - 1);
    localparam logic [SYM_W-1:0] SYM_END  = SYM_W'(ALPHA_SIZE);

    t_state             r_state, n_state;
    logic [SYM_W-1:0]   r_cnt, n_cnt;
    logic [SYM_W-1:0]   r_sym, n_sym;
    logic [NODE_AW-1:0] r_walk, n_walk;
    logic [NODE_AW-1:0] r_fresh, n_fresh;
    logic [NODE_AW-1:0] r_twin, n_twin;
    logic [NODE_AW-1:0] r_target, n_target;
    logic [LEN_W-1:0]   r_walk_len, n_walk_len;
    t_node              r_tgt, n_tgt;
    logic [LINK_W-1:0]  r_flink, n_flink;
    logic               r_cloned, n_cloned;
    logic [NODE_AW-1:0] r_last, n_last;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [LEN_W-1:0]   r_tlen, n_tlen;
    logic [NODE_AW-1:0] r_qnode, n_qnode;
    logic               r_qdead, n_qdead;
    t_status            r_status, n_status;
    logic [END_W-1:0]   r_end, n_end;
    logic [NODE_AW-1:0] qn;
    logic               qd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_cnt    <= '0;
            r_last   <= '0;
            r_count  <= CNT_W'(1);
            r_tlen   <= '0;
            r_qnode  <= '0;
            r_qdead  <= 1'b0;
            r_cloned <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_last   <= n_last;
            r_count  <= n_count;
            r_tlen   <= n_tlen;
            r_qnode  <= n_qnode;
            r_qdead  <= n_qdead;
            r_cloned <= n_cloned;
        end
        r_sym      <= n_sym;
        r_walk     <= n_walk;
        r_fresh    <= n_fresh;
        r_twin     <= n_twin;
        r_target   <= n_target;
        r_walk_len <= n_walk_len;
        r_tgt      <= n_tgt;
        r_flink    <= n_flink;
        r_status   <= n_status;
        r_end      <= n_end;
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_sym      = r_sym;
        n_walk     = r_walk;
        n_fresh    = r_fresh;
        n_twin     = r_twin;
        n_target   = r_target;
        n_walk_len = r_walk_len;
        n_tgt      = r_tgt;
        n_flink    = r_flink;
        n_cloned   = r_cloned;
        n_last     = r_last;
        n_count    = r_count;
        n_tlen     = r_tlen;
        n_qnode    = r_qnode;
        n_qdead    = r_qdead;
        n_status   = r_status;
        n_end      = r_end;
        o_ready    = 1'b0;
        o_tport    = '0;
        o_nport    = '0;
        o_res      = '0;
        qn         = i_restart ? '0 : r_qnode;
        qd         = i_restart ? 1'b0 : r_qdead;
        unique case (r_state)
            S_INIT: begin
                o_tport.we    = 1'b1;
                o_tport.waddr = {NODE_AW'(0), r_cnt};
                o_nport.we    = (r_cnt == '0);
                o_nport.wdata = '{fe: '0, link: LINK_NONE, len: '0};
                n_cnt         = r_cnt + SYM_W'(1);
                if (r_cnt == SYM_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                o_tport.raddr = {qn, i_sym};
                if (i_valid) begin
                    n_sym = i_sym;
                    n_end = '0;
                    if (i_req == REQ_APPEND) begin
                        if (r_tlen == LEN_W'(TEXT_MAX) || i_sym >= SYM_END) begin
                            n_status = ST_FULL;
                            n_state  = S_DONE;
                        end else begin
                            n_fresh  = r_count[NODE_AW-1:0];
                            n_cloned = 1'b0;
                            n_cnt    = '0;
                            n_state  = S_CLR;
                        end
                    end else begin
                        n_qnode = qn;
                        if (qd || i_sym >= SYM_END) begin
                            n_qdead  = 1'b1;
                            n_status = ST_MISS;
                            n_state  = S_DONE;
                        end else begin
                            n_qdead = 1'b0;
                            n_state = S_QCHK;
                        end
                    end
                end
            end
            S_QCHK: begin
                o_nport.raddr = i_trd;
                if (i_trd == '0) begin
                    n_qdead  = 1'b1;
                    n_status = ST_MISS;
                    n_state  = S_DONE;
                end else begin
                    n_qnode = i_trd;
                    n_state = S_QFE;
                end
            end
            S_QFE: begin
                n_end    = i_nrd.fe;
                n_status = ST_OK;
                n_state  = S_DONE;
            end
            S_CLR: begin
                o_tport.we    = 1'b1;
                o_tport.waddr = {r_fresh, r_cnt};
                n_cnt         = r_cnt + SYM_W'(1);
                if (r_cnt == SYM_LAST) begin
                    n_walk  = r_last;
                    n_state = S_WRD;
                end
            end
            S_WRD: begin
                o_tport.raddr = {r_walk, r_sym};
                o_nport.raddr = r_walk;
                n_state       = S_WCHK;
            end
            S_WCHK: begin
                n_walk_len = i_nrd.len;
                if (i_trd == '0) begin
                    o_tport.we    = 1'b1;
                    o_tport.waddr = {r_walk, r_sym};
                    o_tport.wdata = r_fresh;
                    if (i_nrd.link == LINK_NONE) begin
                        n_flink = '0;
                        n_state = S_FIN;
                    end else begin
                        n_walk  = i_nrd.link[NODE_AW-1:0];
                        n_state = S_WRD;
                    end
                end else begin
                    n_target      = i_trd;
                    o_nport.raddr = i_trd;
                    n_state       = S_TCHK;
                end
            end
            S_TCHK: begin
                n_tgt = i_nrd;
                if (i_nrd.len == r_walk_len + LEN_W'(1)) begin
                    n_flink = {1'b0, r_target};
                    n_state = S_FIN;
                end else begin
                    n_twin        = r_fresh + NODE_AW'(1);
                    n_cloned      = 1'b1;
                    o_nport.we    = 1'b1;
                    o_nport.waddr = r_fresh + NODE_AW'(1);
                    o_nport.wdata = '{fe: i_nrd.fe, link: i_nrd.link,
                                      len: r_walk_len + LEN_W'(1)};
                    n_cnt         = '0;
                    n_state       = S_COPY;
                end
            end
            S_COPY: begin
                o_tport.raddr = {r_target, r_cnt};
                o_tport.we    = (r_cnt != '0);
                o_tport.waddr = {r_twin, r_cnt - SYM_W'(1)};
                o_tport.wdata = i_trd;
                n_cnt         = r_cnt + SYM_W'(1);
                if (r_cnt == SYM_END) begin
                    n_state = S_RRD;
                end
            end
            S_RRD: begin
                o_tport.raddr = {r_walk, r_sym};
                o_nport.raddr = r_walk;
                n_state       = S_RCHK;
            end
            S_RCHK: begin
                if (i_trd == r_target) begin
                    o_tport.we    = 1'b1;
                    o_tport.waddr = {r_walk, r_sym};
                    o_tport.wdata = r_twin;
                    if (i_nrd.link == LINK_NONE) begin
                        n_state = S_TFIX;
                    end else begin
                        n_walk  = i_nrd.link[NODE_AW-1:0];
                        n_state = S_RRD;
                    end
                end else begin
                    n_state = S_TFIX;
                end
            end
            S_TFIX: begin
                o_nport.we    = 1'b1;
                o_nport.waddr = r_target;
                o_nport.wdata = '{fe: r_tgt.fe, link: {1'b0, r_twin}, len: r_tgt.len};
                n_flink       = {1'b0, r_twin};
                n_state       = S_FIN;
            end
            S_FIN: begin
                o_nport.we    = 1'b1;
                o_nport.waddr = r_fresh;
                o_nport.wdata = '{fe: r_tlen[END_W-1:0], link: r_flink,
                                  len: r_tlen + LEN_W'(1)};
                n_last   = r_fresh;
                n_tlen   = r_tlen + LEN_W'(1);
                n_count  = r_count + (r_cloned ? CNT_W'(2) : CNT_W'(1));
                n_status = ST_OK;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (i_slot_free) begin
                    o_res.valid   = 1'b1;
                    o_res.status  = r_status;
                    o_res.end_pos = r_end;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

/* rtl/suffix_automaton_index.sv */
// Suffix automaton index. Each input word is an append of one symbol to the
// text or one query step of a pattern, and gives exactly one result word.
// One request is worked at a time by a sequencer around two single-port-write
// memories (node records and a 32-slot transition row per node), each with a
// registered read. A query step reads the transition, then the node record of
// the target when one exists. An append clears the new row, then walks the
// suffix links from the last node and stops early at an existing transition.
// A clone copies the row of the cloned node, redirects each link along the
// walk that points to it, and then updates its suffix link. A rejected append
// or a step of a dead pattern goes straight to the result. Every request also
// waits while the previous result word is held by m_axis_tready. After reset
// the root row is cleared, and no word is accepted until that is done.
module suffix_automaton_index import sai_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [4:0] symbol
    input  logic [1:0]  s_axis_tuser,   // [0] req_type, [1] restart
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [1:0] status, [13:2] end_pos
);
`include "suffix_automaton_index_assert.svh"

    t_tport             tport;
    t_nport             nport;
    logic [NODE_AW-1:0] trd;
    logic [NODE_W-1:0]  nrd;
    t_result            res;
    logic               slot_free;
    logic               r_mvalid;
    t_status            r_mstatus;
    logic [END_W-1:0]   r_mend;

    assign slot_free = !r_mvalid || m_axis_tready;

    sai_ram #(.W(NODE_AW), .AW(TRANS_AW)) u_trans (
        .i_clk   (i_clk),
        .i_we    (tport.we),
        .i_waddr (tport.waddr),
        .i_wdata (tport.wdata),
        .i_raddr (tport.raddr),
        .o_rdata (trd)
    );

    sai_ram #(.W(NODE_W), .AW(NODE_AW)) u_node (
        .i_clk   (i_clk),
        .i_we    (nport.we),
        .i_waddr (nport.waddr),
        .i_wdata (nport.wdata),
        .i_raddr (nport.raddr),
        .o_rdata (nrd)
    );

    sai_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_req       (s_axis_tuser[0]),
        .i_sym       (s_axis_tdata[SYM_W-1:0]),
        .i_restart   (s_axis_tuser[1]),
        .o_tport     (tport),
        .i_trd       (trd),
        .o_nport     (nport),
        .i_nrd       (t_node'(nrd)),
        .i_slot_free (slot_free),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
        end else if (res.valid) begin
            r_mvalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_mvalid <= 1'b0;
        end
        if (res.valid) begin
            r_mstatus <= res.status;
            r_mend    <= res.end_pos;
        end
    end

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = {2'b00, r_mend, r_mstatus};

    `SAI_ASSERT_NOW(a_res_slot, res.valid, slot_free)
    `SAI_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `SAI_ASSERT_NOW(a_res_code, res.valid, res.status != 2'd3)
    `SAI_ASSERT_NOW(a_no_dual_write, res.valid, !tport.we && !nport.we)
endmodule

/* bench/tb_suffix_automaton_index.sv */
class sai_scoreboard;
    localparam int unsigned NODES   = 2 * sai_pkg::TEXT_MAX;
    localparam int unsigned NO_LINK = 32'hFFFF_FFFF;

    typedef struct {
        sai_pkg::t_status  status;
        logic [11:0]       end_pos;
    } t_answer;

    int unsigned node_len [NODES];
    int unsigned node_link[NODES];
    int unsigned node_fe  [NODES];
    int unsigned node_next[NODES][sai_pkg::ALPHA_SIZE];
    int unsigned last_node, node_count, text_len, walk_node;
    bit          walk_dead;
    logic [4:0]  text_syms[$];
    t_answer     answers[$];
    int          errors;

    function void clear();
        node_len[0]  = 0;
        node_link[0] = NO_LINK;
        for (int s = 0; s < sai_pkg::ALPHA_SIZE; s++) node_next[0][s] = 0;
        last_node  = 0;
        node_count = 1;
        text_len   = 0;
        walk_node  = 0;
        walk_dead  = 0;
        errors     = 0;
        text_syms.delete();
        answers.delete();
    endfunction

    function void extend(int unsigned sym);
        int unsigned fresh, walk, target, twin;
        fresh = node_count++;
        walk  = last_node;
        node_len[fresh] = node_len[last_node] + 1;
        node_fe[fresh]  = text_len;
        for (int s = 0; s < sai_pkg::ALPHA_SIZE; s++) node_next[fresh][s] = 0;
        while (walk != NO_LINK && node_next[walk][sym] == 0) begin
            node_next[walk][sym] = fresh;
            walk = node_link[walk];
        end
        if (walk == NO_LINK) begin
            node_link[fresh] = 0;
        end else begin
            target = node_next[walk][sym];
            if (node_len[target] == node_len[walk] + 1) begin
                node_link[fresh] = target;
            end else begin
                twin = node_count++;
                node_len[twin]  = node_len[walk] + 1;
                node_link[twin] = node_link[target];
                node_fe[twin]   = node_fe[target];
                node_next[twin] = node_next[target];
                while (walk != NO_LINK && node_next[walk][sym] == target) begin
                    node_next[walk][sym] = twin;
                    walk = node_link[walk];
                end
                node_link[target] = twin;
                node_link[fresh]  = twin;
            end
        end
        last_node = fresh;
        text_len++;
        text_syms.push_back(sym[4:0]);
    endfunction

    function void note(logic req, logic [4:0] sym, logic restart);
        t_answer     a;
        int unsigned nxt;
        a.status  = sai_pkg::ST_OK;
        a.end_pos = '0;
        if (req == sai_pkg::REQ_APPEND) begin
            if (text_len >= sai_pkg::TEXT_MAX || sym >= sai_pkg::ALPHA_SIZE)
                a.status = sai_pkg::ST_FULL;
            else
                extend(sym);
        end else begin
            if (restart) begin
                walk_node = 0;
                walk_dead = 0;
            end
            if (!walk_dead) begin
                nxt = (sym < sai_pkg::ALPHA_SIZE) ? node_next[walk_node][sym] : 0;
                if (nxt == 0) begin
                    walk_dead = 1;
                end else begin
                    walk_node = nxt;
                    a.end_pos = node_fe[nxt][11:0];
                end
            end
            if (walk_dead) a.status = sai_pkg::ST_MISS;
        end
        answers.push_back(a);
    endfunction

    task report(string what, int got, int want);
        $display("error: %s got %0d expected %0d", what, got, want);
        errors++;
    endtask

    task check(logic [15:0] word);
        t_answer a;
        if (answers.size() == 0) begin
            report("unexpected word, status", word[1:0], -1);
        end else begin
            a = answers.pop_front();
            if (word[1:0] !== a.status) report("status", word[1:0], a.status);
            if (word[13:2] !== a.end_pos) report("end_pos", word[13:2], a.end_pos);
        end
    endtask

    function int pending();
        return answers.size();
    endfunction
endclass

module tb_suffix_automaton_index;
    timeunit 1ns;
    timeprecision 1ps;
    import sai_pkg::*;

    localparam int STALL_LIMIT = 60000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;

    sai_scoreboard sb = new();
    int tx_idle_pct;
    int rx_stall_pct;
    int quiet_cycles;

    suffix_automaton_index DUT (.*);

    always #1 i_clk = ~i_clk;

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        m_axis_tready <= 1'b0;
    end

    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) sb.check(m_axis_tdata);
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task send(logic req, logic [4:0] sym, logic restart);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, sym};
        s_axis_tuser  <= {restart, req};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        sb.note(req, sym, restart);
    endtask

    task drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task append_random();
        int r;
        r = $urandom_range(99);
        if (r < 80)      send(REQ_APPEND, 5'($urandom_range(3)), 1'($urandom_range(1)));
        else if (r < 95) send(REQ_APPEND, 5'($urandom_range(25)), 1'($urandom_range(1)));
        else             send(REQ_APPEND, 5'($urandom_range(31)), 1'($urandom_range(1)));
    endtask

    task run_random(int count);
        int n, start, len, k;
        logic [4:0] sym;
        n = 0;
        while (n < count) begin
            if ($urandom_range(99) < 45) begin
                append_random();
                n++;
            end else if (sb.text_syms.size() > 0 && $urandom_range(9) < 8) begin
                start = $urandom_range(sb.text_syms.size() - 1);
                len   = $urandom_range(1, 12);
                for (k = 0; k < len; k++) begin
                    if (start + k < sb.text_syms.size() && $urandom_range(19) != 0)
                        sym = sb.text_syms[start + k];
                    else
                        sym = 5'($urandom_range(31));
                    send(REQ_QUERY, sym, k == 0);
                    n++;
                end
            end else begin
                send(REQ_QUERY, 5'($urandom_range(31)), 1'($urandom_range(1)));
                n++;
            end
        end
    endtask

    initial begin
        sb.clear();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty text, then extremes, rejects and dead pattern handling
        send(REQ_QUERY,  5'd0,  1'b1);
        send(REQ_QUERY,  5'd0,  1'b0);
        send(REQ_APPEND, 5'd0,  1'b1);
        send(REQ_APPEND, 5'd25, 1'b0);
        send(REQ_APPEND, 5'd26, 1'b0);
        send(REQ_APPEND, 5'd31, 1'b1);
        send(REQ_APPEND, 5'd0,  1'b0);
        send(REQ_APPEND, 5'd25, 1'b0);
        send(REQ_APPEND, 5'd0,  1'b0);
        send(REQ_APPEND, 5'd1,  1'b0);
        send(REQ_QUERY,  5'd0,  1'b1);
        send(REQ_QUERY,  5'd25, 1'b0);
        send(REQ_QUERY,  5'd0,  1'b0);
        send(REQ_QUERY,  5'd31, 1'b0);
        send(REQ_QUERY,  5'd0,  1'b0);
        send(REQ_QUERY,  5'd25, 1'b1);
        send(REQ_APPEND, 5'd25, 1'b0);
        send(REQ_QUERY,  5'd25, 1'b0);
        send(REQ_QUERY,  5'd30, 1'b1);
        send(REQ_QUERY,  5'd0,  1'b1);

        run_random(250);
        tx_idle_pct = 88;
        run_random(250);
        tx_idle_pct  = 0;
        rx_stall_pct = 88;
        run_random(250);
        tx_idle_pct  = 32;
        rx_stall_pct = 32;
        run_random(250);

        // hold off until every result is back, then resume
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        drain();
        run_random(100);

        rx_stall_pct = 50;
        run_random(60);

        drain();
        repeat (100) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
